FILE: design/gbom_pkg.sv
package gbom_pkg;

    localparam int MAX_CANDIDATES_DEF = 64;
    localparam int COORD_BITS_DEF     = 15;

    localparam int IN_COORD_W = 15;
    localparam int TAG_W      = 2;
    localparam int THR_W      = 16;
    localparam int LIM_W      = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SLOT_W     = 6;
    localparam int STATUS_W   = 3;

    localparam logic [THR_W-1:0] THR_RESET = 16'd9830;
    localparam logic [LIM_W-1:0] LIM_RESET = 16'd240;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd2;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MATCH = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED   = 3'd0,
        ST_REJECTED = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_CENTRE   = 3'd3,
        ST_NOMATCH  = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef struct packed {
        t_status                  status;
        logic [SLOT_W-1:0]        slot;
        logic signed [TAG_W-1:0]  team;
    } t_res;

    localparam int RES_W = $bits(t_res);

endpackage

FILE: design/gbom_fifo.sv
module gbom_fifo
    import gbom_pkg::*;
#(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [DW-1:0] i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [DW-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] r_mem [DEPTH];
    logic [AW-1:0] r_wp;
    logic [AW-1:0] r_rp;
    logic [CW-1:0] r_cnt;
    logic          w_wr;
    logic          w_rd;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_wr) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
            end
            if (w_rd) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

FILE: design/gbom_mul.sv
module gbom_mul
    import gbom_pkg::*;
#(
    parameter int AW = 30,
    parameter int BW = 31
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_prod,
    output logic             o_done
);
    localparam int HA    = (AW + 1) / 2;
    localparam int HB    = (BW + 1) / 2;
    localparam int ACC_W = 2 * HA + 2 * HB;

    logic [2*HA-1:0]  w_ax;
    logic [2*HB-1:0]  w_bx;
    logic [HA-1:0]    w_ah;
    logic [HB-1:0]    w_bh;
    logic [2:0]       r_step;
    logic             r_busy;
    logic             r_pval;
    logic             r_done;
    logic [1:0]       r_psel;
    logic [HA+HB-1:0] r_part;
    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] w_shifted;

    assign w_ax = (2 * HA)'(i_a);
    assign w_bx = (2 * HB)'(i_b);
    assign w_ah = r_step[1] ? w_ax[2*HA-1:HA] : w_ax[HA-1:0];
    assign w_bh = r_step[0] ? w_bx[2*HB-1:HB] : w_bx[HB-1:0];

    always_comb begin
        case (r_psel)
            2'd0:    w_shifted = ACC_W'(r_part);
            2'd1:    w_shifted = ACC_W'(r_part) << HB;
            2'd2:    w_shifted = ACC_W'(r_part) << HA;
            default: w_shifted = ACC_W'(r_part) << (HA + HB);
        endcase
    end

    // Four half-by-half partial products, each registered before it is added.
    always_ff @(posedge i_clk) begin
        if (r_busy && !r_step[2]) begin
            r_part <= (HA + HB)'(w_ah) * (HA + HB)'(w_bh);
            r_psel <= r_step[1:0];
        end
        if (i_start) begin
            r_acc <= '0;
        end else if (r_busy && r_pval) begin
            r_acc <= r_acc + w_shifted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_pval <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_pval <= 1'b0;
            end else if (r_busy) begin
                r_pval <= !r_step[2];
                r_step <= r_step + 3'd1;
                if (r_step[2]) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_prod = r_acc[AW+BW-1:0];
    assign o_done = r_done;

endmodule

FILE: design/gbom_front.sv
module gbom_front
    import gbom_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    output logic                    o_full,
    input  logic [1:0]              i_op,
    input  logic [IN_COORD_W-1:0]   i_left,
    input  logic [IN_COORD_W-1:0]   i_top,
    input  logic [IN_COORD_W-1:0]   i_right,
    input  logic [IN_COORD_W-1:0]   i_bottom,
    input  logic signed [TAG_W-1:0] i_team_tag,
    output logic                    o_valid,
    input  logic                    i_pop,
    output t_op                     o_op,
    output logic                    o_good,
    output logic [COORD_BITS-1:0]   o_left,
    output logic [COORD_BITS-1:0]   o_top,
    output logic [COORD_BITS-1:0]   o_right,
    output logic [COORD_BITS-1:0]   o_bottom,
    output logic signed [TAG_W-1:0] o_tag
);
    localparam int C  = COORD_BITS;
    localparam int DW = 2 + 1 + 4 * C + TAG_W;

    logic [C-1:0]  w_l;
    logic [C-1:0]  w_t;
    logic [C-1:0]  w_r;
    logic [C-1:0]  w_b;
    logic          w_known;
    logic          w_good;
    logic          w_empty;
    logic [DW-1:0] w_in;
    logic [DW-1:0] w_out;

    assign w_l = C'(i_left);
    assign w_t = C'(i_top);
    assign w_r = C'(i_right);
    assign w_b = C'(i_bottom);

    // An unknown op is taken and dropped without a result.
    assign w_known = (i_op == OP_CLEAR) || (i_op == OP_LOAD) || (i_op == OP_MATCH);
    assign w_good  = (w_r > w_l) && (w_b > w_t);
    assign w_in    = {i_op, w_good, w_l, w_t, w_r, w_b, i_team_tag};

    gbom_fifo #(
        .DW    (DW),
        .DEPTH (2)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && w_known),
        .i_data  (w_in),
        .o_full  (o_full),
        .i_pop   (i_pop),
        .o_empty (w_empty),
        .o_data  (w_out)
    );

    assign o_valid  = !w_empty;
    assign o_op     = t_op'(w_out[DW-1 -: 2]);
    assign o_good   = w_out[DW-3];
    assign o_left   = w_out[TAG_W+4*C-1 -: C];
    assign o_top    = w_out[TAG_W+3*C-1 -: C];
    assign o_right  = w_out[TAG_W+2*C-1 -: C];
    assign o_bottom = w_out[TAG_W+C-1 -: C];
    assign o_tag    = w_out[TAG_W-1:0];

endmodule

FILE: design/gbom_back.sv
module gbom_back
    import gbom_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cmd_valid,
    output logic                    o_cmd_pop,
    input  t_op                     i_op,
    input  logic                    i_good,
    input  logic [COORD_BITS-1:0]   i_left,
    input  logic [COORD_BITS-1:0]   i_top,
    input  logic [COORD_BITS-1:0]   i_right,
    input  logic [COORD_BITS-1:0]   i_bottom,
    input  logic signed [TAG_W-1:0] i_tag,
    input  logic [THR_W-1:0]        i_thr,
    input  logic [LIM_W-1:0]        i_lim,
    input  logic                    i_en,
    input  logic                    i_res_full,
    output logic                    o_res_push,
    output t_res                    o_res
);
    localparam int C      = COORD_BITS;
    localparam int IW     = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
    localparam int CNTW   = $clog2(MAX_CANDIDATES + 1);
    localparam int AREA_W = 2 * C;
    localparam int UNI_W  = 2 * C + 1;
    localparam int SUM_W  = C + 1;
    localparam int SQ_W   = 2 * SUM_W;
    localparam int D_W    = SQ_W + 1;
    localparam int LSQ_W  = 2 * (LIM_W + 1);
    localparam int BD_W   = (D_W > LSQ_W) ? D_W : LSQ_W;
    localparam int PROD_W = AREA_W + UNI_W;
    localparam int CMP_W  = THR_W + UNI_W;
    localparam int XW     = IW + SLOT_W;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SETUP = 10'b00_0000_0010,
        S_READ  = 10'b00_0000_0100,
        S_GEO   = 10'b00_0000_1000,
        S_AREA  = 10'b00_0001_0000,
        S_UNI   = 10'b00_0010_0000,
        S_MUL   = 10'b00_0100_0000,
        S_DEC   = 10'b00_1000_0000,
        S_FIN   = 10'b01_0000_0000,
        S_RES   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [4*C-1:0] r_box_mem  [MAX_CANDIDATES];
    logic           r_used_mem [MAX_CANDIDATES];
    logic [4*C-1:0] r_rd_box;
    logic           r_rd_used;

    logic [CNTW-1:0]         r_count;
    logic [IW-1:0]           r_idx;
    logic [C-1:0]            r_ql, r_qt, r_qr, r_qb;
    logic signed [TAG_W-1:0] r_tag;
    logic [AREA_W-1:0]       r_qarea;
    logic [SUM_W-1:0]        r_qcx, r_qcy;
    logic [C-1:0]            r_iw, r_ih, r_cw, r_ch;
    logic [SUM_W-1:0]        r_dx, r_dy;
    logic [AREA_W-1:0]       r_inter, r_carea;
    logic [SQ_W-1:0]         r_dx2, r_dy2;
    logic [UNI_W-1:0]        r_uni;
    logic                    r_start;
    logic                    r_have_best;
    logic [IW-1:0]           r_best_idx;
    logic [AREA_W-1:0]       r_best_inter;
    logic [UNI_W-1:0]        r_best_union;
    logic                    r_have_c;
    logic [IW-1:0]           r_c_idx;
    logic [BD_W-1:0]         r_best_d;
    t_res                    r_res;

    logic [C-1:0]      w_cl, w_ct, w_cr, w_cb;
    logic [C-1:0]      w_x1, w_y1, w_x2, w_y2;
    logic [SUM_W-1:0]  w_ccx, w_ccy;
    logic [D_W-1:0]    w_d;
    logic              w_last;
    logic              w_load_ok;
    logic [CMP_W-1:0]  w_thr_prod;
    logic [PROD_W-1:0] w_lhs, w_rhs;
    logic              w_thr_done, w_lhs_done, w_rhs_done;
    logic              w_qual;
    logic [LIM_W:0]    w_lim2;
    logic [XW-1:0]     w_best_x, w_c_x, w_cnt_x;

    assign {w_cl, w_ct, w_cr, w_cb} = r_rd_box;
    assign w_x1  = (r_ql > w_cl) ? r_ql : w_cl;
    assign w_y1  = (r_qt > w_ct) ? r_qt : w_ct;
    assign w_x2  = (r_qr < w_cr) ? r_qr : w_cr;
    assign w_y2  = (r_qb < w_cb) ? r_qb : w_cb;
    assign w_ccx = SUM_W'(w_cl) + SUM_W'(w_cr);
    assign w_ccy = SUM_W'(w_ct) + SUM_W'(w_cb);
    assign w_d   = D_W'(r_dx2) + D_W'(r_dy2);
    assign w_last    = (CNTW'(r_idx) + CNTW'(1)) == r_count;
    assign w_load_ok = i_good && (r_count < CNTW'(MAX_CANDIDATES));
    assign w_lim2    = {i_lim, 1'b0};
    assign w_qual    = CMP_W'({r_inter, {THR_W{1'b0}}}) >= w_thr_prod;
    assign w_best_x  = XW'(r_best_idx);
    assign w_c_x     = XW'(r_c_idx);
    assign w_cnt_x   = XW'(r_count);

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_res_push = (r_state == S_RES) && !i_res_full;
    assign o_res      = r_res;

    gbom_mul #(.AW(THR_W), .BW(UNI_W)) u_thr_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_start),
        .i_a (i_thr), .i_b (r_uni), .o_prod (w_thr_prod), .o_done (w_thr_done)
    );

    gbom_mul #(.AW(AREA_W), .BW(UNI_W)) u_lhs_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_start),
        .i_a (r_inter), .i_b (r_best_union), .o_prod (w_lhs), .o_done (w_lhs_done)
    );

    gbom_mul #(.AW(AREA_W), .BW(UNI_W)) u_rhs_mul (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_start (r_start),
        .i_a (r_best_inter), .i_b (r_uni), .o_prod (w_rhs), .o_done (w_rhs_done)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_op == OP_MATCH && i_en && i_good) begin
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_RES;
                    end
                end
            end
            S_SETUP: n_state = (r_count == '0) ? S_FIN : S_READ;
            S_READ:  n_state = S_GEO;
            S_GEO: begin
                if (r_rd_used) begin
                    n_state = w_last ? S_FIN : S_READ;
                end else begin
                    n_state = S_AREA;
                end
            end
            S_AREA: n_state = S_UNI;
            S_UNI: begin
                if (r_inter != '0) begin
                    n_state = S_MUL;
                end else begin
                    n_state = w_last ? S_FIN : S_READ;
                end
            end
            S_MUL:   n_state = w_thr_done ? S_DEC : S_MUL;
            S_DEC:   n_state = w_last ? S_FIN : S_READ;
            S_FIN:   n_state = S_RES;
            S_RES:   n_state = i_res_full ? S_RES : S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Entries at or above the count are never read, and a load clears the
    // used mark of its entry, so the store needs no clearing at all.
    always_ff @(posedge i_clk) begin
        r_rd_box  <= r_box_mem[r_idx];
        r_rd_used <= r_used_mem[r_idx];
        if (r_state == S_IDLE && i_cmd_valid && i_op == OP_LOAD && w_load_ok) begin
            r_box_mem[r_count[IW-1:0]]  <= {i_left, i_top, i_right, i_bottom};
        end
        if (r_state == S_IDLE && i_cmd_valid && i_op == OP_LOAD && w_load_ok) begin
            r_used_mem[r_count[IW-1:0]] <= 1'b0;
        end else if (r_state == S_FIN && r_have_best) begin
            r_used_mem[r_best_idx] <= 1'b1;
        end else if (r_state == S_FIN && r_have_c) begin
            r_used_mem[r_c_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_ql  <= i_left;
            r_qt  <= i_top;
            r_qr  <= i_right;
            r_qb  <= i_bottom;
            r_tag <= i_tag;
        end
        if (r_state == S_SETUP) begin
            r_qarea <= AREA_W'(r_qr - r_ql) * AREA_W'(r_qb - r_qt);
            r_qcx   <= SUM_W'(r_ql) + SUM_W'(r_qr);
            r_qcy   <= SUM_W'(r_qt) + SUM_W'(r_qb);
        end
        if (r_state == S_GEO) begin
            r_iw <= (w_x2 > w_x1) ? w_x2 - w_x1 : '0;
            r_ih <= (w_y2 > w_y1) ? w_y2 - w_y1 : '0;
            r_cw <= w_cr - w_cl;
            r_ch <= w_cb - w_ct;
            r_dx <= (r_qcx > w_ccx) ? r_qcx - w_ccx : w_ccx - r_qcx;
            r_dy <= (r_qcy > w_ccy) ? r_qcy - w_ccy : w_ccy - r_qcy;
        end
        if (r_state == S_AREA) begin
            r_inter <= AREA_W'(r_iw) * AREA_W'(r_ih);
            r_carea <= AREA_W'(r_cw) * AREA_W'(r_ch);
            r_dx2   <= SQ_W'(r_dx) * SQ_W'(r_dx);
            r_dy2   <= SQ_W'(r_dy) * SQ_W'(r_dy);
        end
        if (r_state == S_UNI) begin
            r_uni <= UNI_W'(r_qarea) + UNI_W'(r_carea) - UNI_W'(r_inter);
        end
        if (r_state == S_SETUP) begin
            r_best_inter <= '0;
            r_best_union <= UNI_W'(1);
        end else if (r_state == S_DEC && w_qual && (!r_have_best || w_lhs > w_rhs)) begin
            r_best_inter <= r_inter;
            r_best_union <= r_uni;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_start     <= 1'b0;
            r_have_best <= 1'b0;
            r_best_idx  <= '0;
            r_have_c    <= 1'b0;
            r_c_idx     <= '0;
            r_best_d    <= '0;
            r_res       <= '{status: ST_NOMATCH, slot: '0, team: '0};
        end else begin
            r_state <= n_state;
            r_start <= (r_state == S_UNI) && (r_inter != '0);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_op)
                            OP_CLEAR: begin
                                r_count <= '0;
                                r_res   <= '{status: ST_CLEARED, slot: '0, team: '0};
                            end
                            OP_LOAD: begin
                                if (w_load_ok) begin
                                    r_count <= r_count + CNTW'(1);
                                    r_res   <= '{status: ST_LOADED,
                                                 slot: w_cnt_x[SLOT_W-1:0], team: '0};
                                end else begin
                                    r_res <= '{status: ST_REJECTED, slot: '0, team: '0};
                                end
                            end
                            default: r_res <= '{status: ST_NOMATCH, slot: '0, team: '0};
                        endcase
                    end
                end
                S_SETUP: begin
                    r_idx       <= '0;
                    r_have_best <= 1'b0;
                    r_have_c    <= 1'b0;
                    r_best_d    <= BD_W'(LSQ_W'(w_lim2) * LSQ_W'(w_lim2));
                end
                S_GEO: begin
                    if (r_rd_used && !w_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_UNI: begin
                    // Centre fallback: an equal distance moves to the later entry.
                    if (BD_W'(w_d) <= r_best_d) begin
                        r_best_d <= BD_W'(w_d);
                        r_c_idx  <= r_idx;
                        r_have_c <= 1'b1;
                    end
                    if (r_inter == '0 && !w_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_DEC: begin
                    // Only a strictly larger ratio displaces the current best.
                    if (w_qual && (!r_have_best || w_lhs > w_rhs)) begin
                        r_have_best <= 1'b1;
                        r_best_idx  <= r_idx;
                    end
                    if (!w_last) begin
                        r_idx <= r_idx + IW'(1);
                    end
                end
                S_FIN: begin
                    if (r_have_best) begin
                        r_res <= '{status: ST_OVERLAP, slot: w_best_x[SLOT_W-1:0],
                                   team: r_tag};
                    end else if (r_have_c) begin
                        r_res <= '{status: ST_CENTRE, slot: w_c_x[SLOT_W-1:0],
                                   team: r_tag};
                    end else begin
                        r_res <= '{status: ST_NOMATCH, slot: '0, team: '0};
                    end
                end
                default: ;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(MAX_CANDIDATES))
        else $error("candidate count beyond store depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GEO) |-> (CNTW'(r_idx) < r_count))
        else $error("scan reads an entry that was never loaded");

    a_mul_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_thr_done == w_lhs_done) && (w_thr_done == w_rhs_done))
        else $error("multiplier units out of step");

    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_thr_done |-> (r_state == S_MUL))
        else $error("product finished outside the multiply wait");

    a_load_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_cmd_valid && i_op == OP_LOAD && w_load_ok)
        |=> (r_count == $past(r_count) + CNTW'(1)))
        else $error("accepted load did not advance the count");

endmodule

FILE: design/greedy_box_overlap_matcher.sv
// A query's scan time grows with the entries already used, the loaded entries that have
// no overlap and the entries that overlap the query (three multipliers, each summing four
// partial products, run side by side for each overlapping entry).
// Throughput: one item at a time in the scan engine; a 2-item command queue and a 2-item
// result queue let input and output stall independently.
// Reset (synchronous, active low) empties the store and both queues and restores config.
module greedy_box_overlap_matcher
    import gbom_pkg::*;
#(
    parameter int MAX_CANDIDATES = MAX_CANDIDATES_DEF,
    parameter int COORD_BITS     = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic [1:0]              i_op,
    input  logic [IN_COORD_W-1:0]   i_left,
    input  logic [IN_COORD_W-1:0]   i_top,
    input  logic [IN_COORD_W-1:0]   i_right,
    input  logic [IN_COORD_W-1:0]   i_bottom,
    input  logic signed [TAG_W-1:0] i_team_tag,
    output logic                    empty,
    input  logic                    pop,
    output logic [STATUS_W-1:0]     o_status,
    output logic [SLOT_W-1:0]       o_slot,
    output logic signed [TAG_W-1:0] o_team_out,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_W-1:0]        i_cfg_data
);
    localparam int C = COORD_BITS;

    logic [THR_W-1:0] r_thr;
    logic [LIM_W-1:0] r_lim;
    logic             r_en;

    logic                    w_valid;
    logic                    w_pop;
    t_op                     w_op;
    logic                    w_good;
    logic [C-1:0]            w_l, w_t, w_r, w_b;
    logic signed [TAG_W-1:0] w_tag;
    logic                    w_res_full;
    logic                    w_res_push;
    t_res                    w_res;
    logic [RES_W-1:0]        w_res_head;
    t_res                    w_head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
            r_lim <= LIM_RESET;
            r_en  <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr <= i_cfg_data[THR_W-1:0];
                CFG_LIMIT:     r_lim <= i_cfg_data[LIM_W-1:0];
                CFG_ENABLE:    r_en  <= i_cfg_data[0];
                default:       ;
            endcase
        end
    end

    gbom_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_op       (i_op),
        .i_left     (i_left),
        .i_top      (i_top),
        .i_right    (i_right),
        .i_bottom   (i_bottom),
        .i_team_tag (i_team_tag),
        .o_valid    (w_valid),
        .i_pop      (w_pop),
        .o_op       (w_op),
        .o_good     (w_good),
        .o_left     (w_l),
        .o_top      (w_t),
        .o_right    (w_r),
        .o_bottom   (w_b),
        .o_tag      (w_tag)
    );

    gbom_back #(
        .MAX_CANDIDATES (MAX_CANDIDATES),
        .COORD_BITS     (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_valid),
        .o_cmd_pop   (w_pop),
        .i_op        (w_op),
        .i_good      (w_good),
        .i_left      (w_l),
        .i_top       (w_t),
        .i_right     (w_r),
        .i_bottom    (w_b),
        .i_tag       (w_tag),
        .i_thr       (r_thr),
        .i_lim       (r_lim),
        .i_en        (r_en),
        .i_res_full  (w_res_full),
        .o_res_push  (w_res_push),
        .o_res       (w_res)
    );

    gbom_fifo #(
        .DW    (RES_W),
        .DEPTH (2)
    ) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (w_res_head)
    );

    assign w_head     = t_res'(w_res_head);
    assign o_status   = w_head.status;
    assign o_slot     = w_head.slot;
    assign o_team_out = w_head.team;

endmodule
